/* rtl/psc_pkg.sv */
package psc_pkg;

	// fixed geometry of the output texture
	localparam int OUTPUT_SIZE      = 256;
	localparam int ROW_SHIFT        = $clog2(OUTPUT_SIZE);
	localparam int COL_SHIFT        = ROW_SHIFT + 1;

	// default size of the source byte store
	localparam int SOURCE_WORDS_DEF = 131072;

	// field widths
	localparam int DIM_W    = 10;
	localparam int COORD_W  = 8;
	localparam int SADDR_W  = 17;
	localparam int COLOUR_W = 32;
	localparam int BYTE_W   = 8;
	localparam int PIX_W    = 2 * DIM_W + 1;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = DIM_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ROWS    = 1'd1;
	localparam logic [DIM_W-1:0] COLUMNS_RESET = 10'd320;
	localparam logic [DIM_W-1:0] ROWS_RESET    = 10'd240;

	typedef enum logic [1:0] {
		CMD_PAL_WR = 2'd0,
		CMD_SRC_WR = 2'd1,
		CMD_PIX_RD = 2'd2,
		CMD_NOP    = 2'd3
	} psc_cmd_t;

	// input transaction
	typedef struct packed {
		psc_cmd_t             cmd;
		logic [BYTE_W-1:0]    palette_index;
		logic [COLOUR_W-1:0]  palette_colour;
		logic [SADDR_W-1:0]   source_address;
		logic [BYTE_W-1:0]    source_byte;
		logic [COORD_W-1:0]   output_row;
		logic [COORD_W-1:0]   output_column;
	} psc_req_t;

	// result transaction
	typedef struct packed {
		logic [COLOUR_W-1:0] pixel_colour;
		logic                out_of_range;
	} psc_rsp_t;

	// operation carried down the pipeline
	typedef struct packed {
		logic                valid;
		psc_cmd_t            cmd;
		logic [BYTE_W-1:0]   palette_index;
		logic [COLOUR_W-1:0] palette_colour;
		logic [SADDR_W-1:0]  source_address;
		logic [BYTE_W-1:0]   source_byte;
	} psc_op_t;

endpackage

/* rtl/psc_addr_gen.sv */
module psc_addr_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  psc_pkg::psc_req_t           req,
	input  logic [psc_pkg::DIM_W-1:0]   source_columns,
	input  logic [psc_pkg::DIM_W-1:0]   source_rows,
	output psc_pkg::psc_op_t            op_s2,
	output logic [psc_pkg::PIX_W-1:0]   addr_s2
);

	localparam int ROW_PROD_W = psc_pkg::COORD_W + psc_pkg::DIM_W;
	localparam int COL_PROD_W = psc_pkg::COORD_W + 1 + psc_pkg::DIM_W;

	psc_pkg::psc_op_t             op_s1;
	logic [psc_pkg::DIM_W-1:0]    srow_s1;
	logic [psc_pkg::DIM_W-1:0]    scol_s1;
	logic [psc_pkg::DIM_W-1:0]    cols_s1;
	logic [ROW_PROD_W-1:0]        row_prod;
	logic [COL_PROD_W-1:0]        col_prod;
	logic [psc_pkg::COORD_W:0]    col_centre;
	logic [2*psc_pkg::DIM_W-1:0]  row_base;

	// source row and centred source column
	assign col_centre = {req.output_column, 1'b1};
	assign row_prod   = ROW_PROD_W'(req.output_row) * ROW_PROD_W'(source_rows);
	assign col_prod   = COL_PROD_W'(source_columns) * COL_PROD_W'(col_centre);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.valid          <= accept;
			op_s1.cmd            <= req.cmd;
			op_s1.palette_index  <= req.palette_index;
			op_s1.palette_colour <= req.palette_colour;
			op_s1.source_address <= req.source_address;
			op_s1.source_byte    <= req.source_byte;
		end
	end

	always_ff @(posedge clk) begin
		srow_s1 <= psc_pkg::DIM_W'(row_prod >> psc_pkg::ROW_SHIFT);
		scol_s1 <= psc_pkg::DIM_W'(col_prod >> psc_pkg::COL_SHIFT);
		cols_s1 <= source_columns;
	end

	// row-major source address
	assign row_base = (2*psc_pkg::DIM_W)'(cols_s1) * (2*psc_pkg::DIM_W)'(srow_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= '0;
		end else begin
			op_s2.valid          <= op_s1.valid;
			op_s2.cmd            <= op_s1.cmd;
			op_s2.palette_index  <= op_s1.palette_index;
			op_s2.palette_colour <= op_s1.palette_colour;
			op_s2.source_address <= op_s1.source_address;
			op_s2.source_byte    <= op_s1.source_byte;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= psc_pkg::PIX_W'(row_base) + psc_pkg::PIX_W'(scol_s1);
	end

endmodule

/* rtl/psc_source_mem.sv */
module psc_source_mem #(
	parameter int SOURCE_WORDS = psc_pkg::SOURCE_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psc_pkg::psc_op_t            op_s2,
	input  logic [psc_pkg::PIX_W-1:0]   addr_s2,
	output psc_pkg::psc_op_t            op_s3,
	output logic [psc_pkg::BYTE_W-1:0]  byte_s3,
	output logic                        oor_s3
);

	localparam int AW = $clog2(SOURCE_WORDS);

	logic [psc_pkg::BYTE_W-1:0] mem [SOURCE_WORDS];
	logic                       wr_en;
	logic                       rd_oor;
	logic [AW-1:0]              wr_idx;
	logic [AW-1:0]              rd_idx;

	// writes and reads share the stage, so program order holds
	assign wr_en  = op_s2.valid && (op_s2.cmd == psc_pkg::CMD_SRC_WR) &&
			(32'(op_s2.source_address) < 32'(SOURCE_WORDS));
	assign wr_idx = AW'(op_s2.source_address);
	assign rd_idx = AW'(addr_s2);
	assign rd_oor = 32'(addr_s2) >= 32'(SOURCE_WORDS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= op_s2.source_byte;
		end
		byte_s3 <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s3 <= '0;
		end else begin
			op_s3.valid          <= op_s2.valid;
			op_s3.cmd            <= op_s2.cmd;
			op_s3.palette_index  <= op_s2.palette_index;
			op_s3.palette_colour <= op_s2.palette_colour;
			op_s3.source_address <= op_s2.source_address;
			op_s3.source_byte    <= op_s2.source_byte;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3 <= rd_oor;
	end

endmodule

/* rtl/psc_palette_mem.sv */
module psc_palette_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psc_pkg::psc_op_t            op_s3,
	input  logic [psc_pkg::BYTE_W-1:0]  byte_s3,
	input  logic                        oor_s3,
	output logic                        rsp_valid,
	output psc_pkg::psc_rsp_t           rsp
);

	localparam int PAL_DEPTH = 1 << psc_pkg::BYTE_W;

	logic [psc_pkg::COLOUR_W-1:0] mem [PAL_DEPTH];
	logic [psc_pkg::COLOUR_W-1:0] colour_s4;
	logic                         oor_s4;
	logic                         rd_en;
	logic                         wr_en;
	logic [psc_pkg::BYTE_W-1:0]   idx;

	// one port: palette write or lookup of the sampled byte
	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		idx   = byte_s3;
		case (op_s3.cmd)
			psc_pkg::CMD_PAL_WR: begin
				wr_en = op_s3.valid;
				idx   = op_s3.palette_index;
			end
			psc_pkg::CMD_PIX_RD: begin
				rd_en = op_s3.valid;
			end
			psc_pkg::CMD_SRC_WR,
			psc_pkg::CMD_NOP: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= op_s3.palette_colour;
		end
		colour_s4 <= mem[idx];
		oor_s4    <= oor_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= rd_en;
		end
	end

	// out-of-range samples read as colour zero
	assign rsp.pixel_colour = oor_s4 ? '0 : colour_s4;
	assign rsp.out_of_range = oor_s4;

endmodule

/* rtl/paletted_nearest_scaler_unit.sv */
// Paletted nearest-neighbour scaler.
// Command channel: a transaction (req) is taken at each rising edge with start
// high and busy low. busy stays low, so a command may be issued every cycle.
// req.cmd selects a palette write, a source byte write or an output pixel read.
// Only pixel reads give a result: rsp_valid is high for exactly one cycle with
// rsp, once the read has passed the registered stages (address multiply,
// address add, source memory read, palette memory read). The receiver cannot
// stall; one result per cycle is sustained. Writes go through the same pipeline
// and reach each memory in the same stage as reads, so commands take effect in
// issue order with no interlock.
// Configuration: cfg_valid/cfg_ready write source_columns (index 0) or
// source_rows (index 1); cfg_ready is always high. Write only when no read is
// in flight.
// Reset: asynchronous, active low; clears the pipeline valids and restores the
// default frame size of 320x240. Memory contents are not cleared.
module paletted_nearest_scaler_unit #(
	parameter int SOURCE_WORDS = psc_pkg::SOURCE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  psc_pkg::psc_req_t              req,
	output logic                           rsp_valid,
	output psc_pkg::psc_rsp_t              rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [psc_pkg::DIM_W-1:0]   source_columns_q;
	logic [psc_pkg::DIM_W-1:0]   source_rows_q;
	logic                        accept;
	psc_pkg::psc_op_t            op_s2;
	psc_pkg::psc_op_t            op_s3;
	logic [psc_pkg::PIX_W-1:0]   addr_s2;
	logic [psc_pkg::BYTE_W-1:0]  byte_s3;
	logic                        oor_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_columns_q <= psc_pkg::COLUMNS_RESET;
			source_rows_q    <= psc_pkg::ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == psc_pkg::CFG_SOURCE_COLUMNS) begin
				source_columns_q <= cfg_data;
			end
			if (cfg_index == psc_pkg::CFG_SOURCE_ROWS) begin
				source_rows_q <= cfg_data;
			end
		end
	end

	psc_addr_gen u_addr_gen (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req            (req),
		.source_columns (source_columns_q),
		.source_rows    (source_rows_q),
		.op_s2          (op_s2),
		.addr_s2        (addr_s2)
	);

	psc_source_mem #(
		.SOURCE_WORDS (SOURCE_WORDS)
	) u_source_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_s2   (op_s2),
		.addr_s2 (addr_s2),
		.op_s3   (op_s3),
		.byte_s3 (byte_s3),
		.oor_s3  (oor_s3)
	);

	psc_palette_mem u_palette_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_s3     (op_s3),
		.byte_s3   (byte_s3),
		.oor_s3    (oor_s3),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int PHASES       = 13;
	localparam int FIXED_PHASES = 9;
	localparam int SETTLE       = 10;
	localparam int ACTIONS      = 70;

	// tracks palette and source memories and predicts each sampled pixel
	class pixel_predictor;
		logic [psc_pkg::COLOUR_W-1:0] palette [psc_pkg::OUTPUT_SIZE];
		logic [psc_pkg::BYTE_W-1:0]   source [psc_pkg::SOURCE_WORDS_DEF];
		bit                           pal_written [psc_pkg::OUTPUT_SIZE];
		bit                           src_written [psc_pkg::SOURCE_WORDS_DEF];
		logic [psc_pkg::DIM_W-1:0]    columns;
		logic [psc_pkg::DIM_W-1:0]    rows;
		psc_pkg::psc_rsp_t            expected_pixels [$];
		int                           errors;

		function new();
			columns = psc_pkg::COLUMNS_RESET;
			rows = psc_pkg::ROWS_RESET;
			errors = 0;
		endfunction

		function void set_register(logic [psc_pkg::CFG_IDX_W-1:0] idx,
				logic [psc_pkg::CFG_DATA_W-1:0] data);
			if (idx == psc_pkg::CFG_SOURCE_COLUMNS) begin
				columns = data;
			end else begin
				rows = data;
			end
		endfunction

		// nearest source address, row sampled at top edge, column at centre
		function int unsigned sample_address(logic [psc_pkg::COORD_W-1:0] orow,
				logic [psc_pkg::COORD_W-1:0] ocol);
			int unsigned srow;
			int unsigned scol;
			srow = (32'(orow) * 32'(rows)) >> psc_pkg::ROW_SHIFT;
			scol = (32'(columns) * (2 * 32'(ocol) + 1)) >> psc_pkg::COL_SHIFT;
			return 32'(columns) * srow + scol;
		endfunction

		// apply one accepted command transaction
		function void absorb_command(psc_pkg::psc_req_t r);
			psc_pkg::psc_rsp_t want;
			int unsigned addr;
			case (r.cmd)
				psc_pkg::CMD_PAL_WR: begin
					palette[r.palette_index] = r.palette_colour;
					pal_written[r.palette_index] = 1'b1;
				end
				psc_pkg::CMD_SRC_WR: begin
					if (r.source_address < psc_pkg::SOURCE_WORDS_DEF) begin
						source[r.source_address] = r.source_byte;
						src_written[r.source_address] = 1'b1;
					end
				end
				psc_pkg::CMD_PIX_RD: begin
					addr = sample_address(r.output_row, r.output_column);
					if (addr >= psc_pkg::SOURCE_WORDS_DEF) begin
						want.pixel_colour = '0;
						want.out_of_range = 1'b1;
					end else begin
						want.pixel_colour = palette[source[psc_pkg::SADDR_W'(addr)]];
						want.out_of_range = 1'b0;
					end
					expected_pixels.push_back(want);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 40) $display("mismatch: %s", what);
			errors++;
		endtask

		task check_pixel(psc_pkg::psc_rsp_t got);
			psc_pkg::psc_rsp_t want;
			if (expected_pixels.size() == 0) begin
				report("pixel result with none outstanding");
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_colour !== want.pixel_colour)
				report($sformatf("pixel_colour got %h want %h", got.pixel_colour,
					want.pixel_colour));
			if (got.out_of_range !== want.out_of_range)
				report($sformatf("out_of_range got %b want %b", got.out_of_range,
					want.out_of_range));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	psc_pkg::psc_req_t              req;
	logic                           rsp_valid;
	psc_pkg::psc_rsp_t              rsp;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [psc_pkg::CFG_DATA_W-1:0] cfg_data;

	pixel_predictor sb;
	bit             no_idle;

	paletted_nearest_scaler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result transactions cannot be held off, check every one
	always @(posedge clk) begin
		if (arst_n && rsp_valid) sb.check_pixel(rsp);
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int k;
		if (no_idle) return 0;
		k = $urandom_range(0, 99);
		if (k < 65) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic psc_pkg::psc_req_t random_command(psc_pkg::psc_cmd_t c);
		psc_pkg::psc_req_t r;
		r.cmd = c;
		r.palette_index = psc_pkg::BYTE_W'($urandom);
		r.palette_colour = $urandom;
		r.source_address = psc_pkg::SADDR_W'($urandom);
		r.source_byte = psc_pkg::BYTE_W'($urandom);
		r.output_row = psc_pkg::COORD_W'($urandom);
		r.output_column = psc_pkg::COORD_W'($urandom);
		return r;
	endfunction

	function automatic logic [psc_pkg::COORD_W-1:0] pick_coord();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return '0;
		if (k == 1) return '1;
		return psc_pkg::COORD_W'($urandom);
	endfunction

	// one command transaction, after an optional gap
	task automatic issue(psc_pkg::psc_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.absorb_command(r);
	endtask

	// hold off until every pixel has come back and the pipe has emptied
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_frame(logic [psc_pkg::DIM_W-1:0] cols,
			logic [psc_pkg::DIM_W-1:0] rws);
		cfg_valid <= 1'b1;
		cfg_index <= psc_pkg::CFG_SOURCE_COLUMNS;
		cfg_data <= cols;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(psc_pkg::CFG_SOURCE_COLUMNS, cols);
		cfg_index <= psc_pkg::CFG_SOURCE_ROWS;
		cfg_data <= rws;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(psc_pkg::CFG_SOURCE_ROWS, rws);
		cfg_valid <= 1'b0;
	endtask

	// make sure the sampled byte and its palette entry exist, then read
	task automatic sample_pixel(logic [psc_pkg::COORD_W-1:0] orow,
			logic [psc_pkg::COORD_W-1:0] ocol);
		psc_pkg::psc_req_t r;
		int unsigned addr;
		logic [psc_pkg::SADDR_W-1:0] sa;
		logic [psc_pkg::BYTE_W-1:0] b;
		addr = sb.sample_address(orow, ocol);
		if (addr < psc_pkg::SOURCE_WORDS_DEF) begin
			sa = psc_pkg::SADDR_W'(addr);
			if (!sb.src_written[sa]) begin
				r = random_command(psc_pkg::CMD_SRC_WR);
				r.source_address = sa;
				issue(r);
			end
			b = sb.source[sa];
			if (!sb.pal_written[b]) begin
				r = random_command(psc_pkg::CMD_PAL_WR);
				r.palette_index = b;
				issue(r);
			end
		end
		r = random_command(psc_pkg::CMD_PIX_RD);
		r.output_row = orow;
		r.output_column = ocol;
		issue(r);
	endtask

	task automatic directed_commands();
		psc_pkg::psc_req_t r;
		// palette extremes
		r = random_command(psc_pkg::CMD_PAL_WR);
		r.palette_index = '0;
		r.palette_colour = '0;
		issue(r);
		r.palette_index = '1;
		r.palette_colour = '1;
		issue(r);
		// first and last source word
		r = random_command(psc_pkg::CMD_SRC_WR);
		r.source_address = '0;
		r.source_byte = '1;
		issue(r);
		r.source_address = psc_pkg::SADDR_W'(psc_pkg::SOURCE_WORDS_DEF - 1);
		r.source_byte = '0;
		issue(r);
		// last word written again
		r.source_address = '1;
		r.source_byte = 8'ha5;
		issue(r);
		// unused command with all ones and all zeros
		r = '1;
		issue(r);
		r = '0;
		r.cmd = psc_pkg::CMD_NOP;
		issue(r);
		sample_pixel(8'd128, 8'd127);
		sample_pixel(8'd1, 8'd0);
	endtask

	task automatic random_action();
		psc_pkg::psc_req_t r;
		int k;
		k = $urandom_range(0, 99);
		if (k < 72) begin
			sample_pixel(pick_coord(), pick_coord());
		end else if (k < 82) begin
			issue(random_command(psc_pkg::CMD_PAL_WR));
		end else if (k < 92) begin
			r = random_command(psc_pkg::CMD_SRC_WR);
			if ($urandom_range(0, 3) != 0)
				r.source_address = psc_pkg::SADDR_W'(
					$urandom_range(0, psc_pkg::SOURCE_WORDS_DEF - 1));
			issue(r);
		end else if (k < 98) begin
			issue(random_command(psc_pkg::CMD_NOP));
		end else begin
			drain();
		end
	endtask

	// frame sizes per phase, the first is the reset size
	logic [psc_pkg::DIM_W-1:0] fixed_cols [FIXED_PHASES] =
		'{10'd320, 10'd1, 10'd512, 10'd0, 10'd1023, 10'd512, 10'd256, 10'd1, 10'd512};
	logic [psc_pkg::DIM_W-1:0] fixed_rows [FIXED_PHASES] =
		'{10'd240, 10'd1, 10'd512, 10'd0, 10'd1023, 10'd256, 10'd515, 10'd512, 10'd1};

	initial begin
		logic [psc_pkg::DIM_W-1:0] cols;
		logic [psc_pkg::DIM_W-1:0] rws;
		sb = new();
		no_idle = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				if (p < FIXED_PHASES) begin
					cols = fixed_cols[p];
					rws = fixed_rows[p];
				end else if (p < FIXED_PHASES + 2) begin
					cols = psc_pkg::DIM_W'($urandom_range(1, 512));
					rws = psc_pkg::DIM_W'($urandom_range(1, 512));
				end else begin
					cols = psc_pkg::DIM_W'($urandom);
					rws = psc_pkg::DIM_W'($urandom);
				end
				write_frame(cols, rws);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			if (p == 0) begin
				directed_commands();
				drain();
			end
			// frame corners
			sample_pixel('0, '0);
			sample_pixel('0, '1);
			sample_pixel('1, '0);
			sample_pixel('1, '1);
			repeat (ACTIONS) random_action();
		end
		drain();

		if (sb.expected_pixels.size() != 0)
			sb.report($sformatf("%0d pixel results never arrived",
				sb.expected_pixels.size()));
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* paletted_nearest_scaler_unit.f */
rtl/psc_pkg.sv
rtl/psc_addr_gen.sv
rtl/psc_source_mem.sv
rtl/psc_palette_mem.sv
rtl/paletted_nearest_scaler_unit.sv
bench/tb_top.sv
